[rtl/core/vpid_pkg.sv]
// Shared types, widths and register codes for the velocity-form PID regulator.
`default_nettype none

package vpid_pkg;

    localparam int DATA_W              = 16;
    localparam int ERR_W               = DATA_W + 1;
    localparam int D1_W                = ERR_W + 1;
    localparam int D2_W                = ERR_W + 2;
    localparam int GAIN_W              = 32;
    localparam int DRIVE_W             = 32;
    localparam int PROD_W              = GAIN_W + D2_W;
    localparam int SUM_W               = PROD_W + 2;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 32;
    localparam int SCALE_SHIFT_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int BACK_STAGES         = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_LIMIT_LOW  = 3'd3,
        CFG_LIMIT_HIGH = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] measured;
    } sample_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
    } result_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [D1_W-1:0]  d1;
        logic signed [D2_W-1:0]  d2;
    } work_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [DRIVE_W-1:0] limit_low;
        logic signed [DRIVE_W-1:0] limit_high;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/vpid_stream_if.sv]
// Valid/ready stream interface used for the sample and result channels.
`default_nettype none

interface vpid_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/vpid_front.sv]
// Front end: accepts samples, forms the error and its differences, keeps the error history.
`default_nettype none

module vpid_front
    import vpid_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    vpid_stream_if.sink  sample,
    input  wire logic    q_full,
    output logic         q_push,
    output work_t        q_data
);

    logic signed [ERR_W-1:0] last_err_reg;
    logic signed [ERR_W-1:0] last_err_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic signed [ERR_W-1:0] err;
    logic signed [D2_W-1:0]  last_twice;

    assign sample.ready = !q_full;
    assign q_push       = sample.valid && !q_full;

    assign err        = ERR_W'(sample.payload.target) - ERR_W'(sample.payload.measured);
    assign last_twice = D2_W'(last_err_reg) <<< 1;

    always_comb
    begin
        q_data.err = err;
        q_data.d1  = D1_W'(err) - D1_W'(last_err_reg);
        q_data.d2  = D2_W'(err) - last_twice + D2_W'(prev_err_reg);
    end

    always_comb
    begin
        last_err_next = last_err_reg;
        prev_err_next = prev_err_reg;
        if (q_push)
        begin
            last_err_next = err;
            prev_err_next = last_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            last_err_reg <= last_err_next;
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/vpid_queue.sv]
// Short register queue between the front end and the arithmetic back end.
`default_nettype none

module vpid_queue
    import vpid_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t push_data,
    output logic       full,
    input  wire logic  pop,
    output work_t      pop_data,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/vpid_back.sv]
// Back end: gain products, scaling, sum, accumulation with clamp and the result register.
`default_nettype none

module vpid_back
    import vpid_pkg::*;
#(
    parameter int SCALE_SHIFT = SCALE_SHIFT_DEFAULT
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    q_empty,
    input  wire work_t   q_data,
    output logic         q_pop,
    vpid_stream_if.source result
);

    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        PROD_W'((64'sd1 <<< SCALE_SHIFT) - 64'sd1);

    function automatic logic signed [PROD_W-1:0] scale_down(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p[PROD_W-1] ? p + ROUND_BIAS : p;
        return biased >>> SCALE_SHIFT;
    endfunction

    logic                      p_valid_reg;
    logic signed [PROD_W-1:0]  prod_p_reg;
    logic signed [PROD_W-1:0]  prod_i_reg;
    logic signed [PROD_W-1:0]  prod_d_reg;
    logic                      t_valid_reg;
    logic signed [PROD_W-1:0]  term_p_reg;
    logic signed [PROD_W-1:0]  term_i_reg;
    logic signed [PROD_W-1:0]  term_d_reg;
    logic                      s_valid_reg;
    logic signed [SUM_W-1:0]   inc_reg;
    logic                      o_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [SUM_W-1:0]   raw_next;

    logic o_ready;
    logic s_ready;
    logic t_ready;
    logic p_ready;

    assign o_ready = !o_valid_reg || result.ready;
    assign s_ready = !s_valid_reg || o_ready;
    assign t_ready = !t_valid_reg || s_ready;
    assign p_ready = !p_valid_reg || t_ready;
    assign q_pop   = !q_empty && p_ready;

    assign result.valid         = o_valid_reg;
    assign result.payload.drive = drive_reg;

    assign raw_next = SUM_W'(drive_reg) + inc_reg;

    always_comb
    begin
        if (raw_next > SUM_W'(cfg.limit_high))
        begin
            drive_next = cfg.limit_high;
        end
        else if (raw_next < SUM_W'(cfg.limit_low))
        begin
            drive_next = cfg.limit_low;
        end
        else
        begin
            drive_next = raw_next[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            drive_reg   <= '0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= !q_empty;
            end
            if (t_ready)
            begin
                t_valid_reg <= p_valid_reg;
            end
            if (s_ready)
            begin
                s_valid_reg <= t_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
                if (s_valid_reg)
                begin
                    drive_reg <= drive_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_p_reg <= PROD_W'(cfg.gain_p) * PROD_W'(q_data.d1);
            prod_i_reg <= PROD_W'(cfg.gain_i) * PROD_W'(q_data.err);
            prod_d_reg <= PROD_W'(cfg.gain_d) * PROD_W'(q_data.d2);
        end
        if (t_ready && p_valid_reg)
        begin
            term_p_reg <= scale_down(prod_p_reg);
            term_i_reg <= scale_down(prod_i_reg);
            term_d_reg <= scale_down(prod_d_reg);
        end
        if (s_ready && t_valid_reg)
        begin
            inc_reg <= SUM_W'(term_p_reg) + SUM_W'(term_i_reg) + SUM_W'(term_d_reg);
        end
    end

endmodule

`default_nettype wire

[rtl/core/velocity_pid_fixed_point.sv]
// Top level of the velocity-form PID regulator with its configuration registers.
//
// Velocity-form PID regulator with Q16.16 gains and clamped output. One sample beat
// (target, measured) yields one result beat (drive). A new sample is taken every cycle
// while the queue is not full; the one-per-cycle rate is set by the accumulator loop in
// the result stage, where the increment is added to the previous drive and clamped to
// the limits ahead of the drive register. A sample passes the queue and four back-end
// stages (products, scaling, sum, accumulate). Up to QUEUE_DEPTH plus four beats may be
// in flight under output stall. Gains and limits are to be written by the user through
// the register port while the block is idle; the block itself does not enforce it.
`default_nettype none

module velocity_pid_fixed_point
    import vpid_pkg::*;
#(
    parameter int SCALE_SHIFT = SCALE_SHIFT_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    vpid_stream_if.sink                sample,
    vpid_stream_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    work_t q_in;
    work_t q_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:     cfg_next.gain_p     = cfg_data;
                CFG_GAIN_I:     cfg_next.gain_i     = cfg_data;
                CFG_GAIN_D:     cfg_next.gain_d     = cfg_data;
                CFG_LIMIT_LOW:  cfg_next.limit_low  = cfg_data;
                CFG_LIMIT_HIGH: cfg_next.limit_high = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= '0;
            cfg_reg.gain_i     <= '0;
            cfg_reg.gain_d     <= '0;
            cfg_reg.limit_low  <= {1'b1, {(DRIVE_W-1){1'b0}}};
            cfg_reg.limit_high <= {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vpid_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    vpid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    vpid_back #(
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

[rtl/core/vpid_checker.sv]
// Port-level assertions for the PID regulator and the bind that attaches them.
`default_nettype none

module vpid_checker
    import vpid_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  sample_valid,
    input wire logic                  sample_ready,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [DRIVE_W-1:0]    result_drive,
    input wire logic                  cfg_we,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CAPACITY = QUEUE_DEPTH + BACK_STAGES;
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    logic [CNT_W-1:0]          pending_reg;
    logic [CNT_W-1:0]          pending_next;
    logic signed [DRIVE_W-1:0] low_reg;
    logic signed [DRIVE_W-1:0] high_reg;
    logic                      in_beat;
    logic                      out_beat;

    assign in_beat  = sample_valid && sample_ready;
    assign out_beat = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            low_reg     <= {1'b1, {(DRIVE_W-1){1'b0}}};
            high_reg    <= {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we && cfg_index_t'(cfg_index) == CFG_LIMIT_LOW)
            begin
                low_reg <= cfg_data;
            end
            if (cfg_we && cfg_index_t'(cfg_index) == CFG_LIMIT_HIGH)
            begin
                high_reg <= cfg_data;
            end
        end
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pending_reg != '0)
        else $error("result beat without a pending sample");

    a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(CAPACITY))
        else $error("more beats in flight than the pipeline holds");

    a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> sample_ready)
        else $error("idle block refuses a sample");

    a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && low_reg <= high_reg) |->
            ($signed(result_drive) >= low_reg && $signed(result_drive) <= high_reg))
        else $error("drive outside the configured limits");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_drive)))
        else $error("stalled result beat changed");

endmodule

bind velocity_pid_fixed_point vpid_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_vpid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_drive (result.payload.drive),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

`default_nettype wire
